// ===== rtl/core/jpp_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Jittered path point: shared package
// Constants of the datapath and the bundles that travel down delay lines.
// ----------------------------------------------------------------------------
package jpp_pkg;

	// Depth of one vector normaliser, in pipeline stages.
	localparam int unsigned NORM_FRONT = 5;
	localparam int unsigned SQRT_STEPS = 32;
	localparam int unsigned DIV_STEPS  = 31;
	localparam int unsigned NORM_LAT   = NORM_FRONT + SQRT_STEPS + DIV_STEPS + 1;

	// Fixed-point constants.
	localparam logic [16:0]        ONE_Q16   = 17'd65536;
	localparam logic signed [31:0] ONE_Q30   = 32'sd1073741824;
	localparam logic [31:0]        STEEP_Y   = 32'd1020054732;
	localparam logic [15:0]        SHORT_SQ  = 16'd4295;
	localparam logic [32:0]        SHORT_MAG = 33'd66;
	localparam logic [26:0]        K_SCALE   = 27'd1000;

	// Hash constants.
	localparam logic [31:0] HASH_MUL  = 32'h045d9f3b;
	localparam logic [31:0] SEED_MUL1 = 32'd7919;
	localparam logic [31:0] SEED_MUL2 = 32'd104729;
	localparam logic [31:0] HASH_ADD  = 32'd17;

	// Bundle carried from the early stages to the final blend.
	typedef struct packed {
		logic [2:0][33:0] base;
		logic             longp;
		logic [32:0]      s1;
		logic [32:0]      s2;
	} side_t;

	// Bundle carried across the hash stages.
	typedef struct packed {
		logic [2:0][33:0] base;
		logic             longp;
		logic [30:0]      amp;
	} front_t;

endpackage

`default_nettype wire

// ===== rtl/core/jpp_delay.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Jittered path point: delay line
// A chain of enable-gated registers that keeps side data aligned with the
// pipeline.
// ----------------------------------------------------------------------------
module jpp_delay #(
	parameter int unsigned WIDTH = 8,
	parameter int unsigned DEPTH = 2
) (
	input  logic             clk,
	input  logic             en,
	input  logic [WIDTH-1:0] din,
	output logic [WIDTH-1:0] dout
);

	logic [WIDTH-1:0] line_s [DEPTH];

	// Shift the whole line by one place whenever the pipeline advances.
	always_ff @(posedge clk) begin
		if (en) begin
			line_s[0] <= din;
			for (int k = 1; k < DEPTH; k++) begin
				line_s[k] <= line_s[k-1];
			end
		end
	end

	assign dout = line_s[DEPTH-1];

endmodule

`default_nettype wire

// ===== rtl/core/jpp_hash.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Jittered path point: hash offset
// Two xor-shift-multiply rounds and a final fold give a Q0.16 offset in
// -0.5 to 0.5. Three pipeline stages.
// ----------------------------------------------------------------------------
module jpp_hash import jpp_pkg::*; (
	input  logic               clk,
	input  logic               en,
	input  logic [31:0]        key,
	output logic signed [16:0] offs
);

	logic [31:0]        p1_s1;
	logic [31:0]        p2_s2;
	logic signed [16:0] q_s3;
	logic [31:0]        x1;
	logic [31:0]        x2;
	logic [15:0]        r;

	// First and second rounds, each a fold followed by a wrapping multiply.
	assign x1 = key ^ (key >> 16);
	assign x2 = p1_s1 ^ (p1_s1 >> 16);
	// Final fold keeps the low half.
	assign r  = p2_s2[15:0] ^ p2_s2[31:16];

	always_ff @(posedge clk) begin
		if (en) begin
			p1_s1 <= 32'(x1 * HASH_MUL);
			p2_s2 <= 32'(x2 * HASH_MUL);
			// Scaling by 65536/65535 with rounding adds one for the upper half.
			q_s3  <= $signed(17'({1'b0, r}) + 17'(r[15]) - 17'd32768);
		end
	end

	assign offs = q_s3;

endmodule

`default_nettype wire

// ===== rtl/core/jpp_norm.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Jittered path point: vector normaliser
// Scales a 3D vector to a Q2.30 unit vector: magnitude scaling, sum of
// squares, a bit-per-stage square root and three bit-per-stage dividers.
// ----------------------------------------------------------------------------
module jpp_norm import jpp_pkg::*; (
	input  logic             clk,
	input  logic             en,
	input  logic [2:0][32:0] vec,
	output logic [2:0][31:0] unit_vec
);

	// Front stages.
	logic [2:0][32:0] mag_c;
	logic [32:0]      mx_c;
	logic [5:0]       lead_c;
	logic [2:0][30:0] sm_c;
	logic [2:0][32:0] mag_s1;
	logic [32:0]      mx_s1;
	logic [2:0]       sgn_s1;
	logic [2:0][32:0] mag_s2;
	logic [5:0]       lead_s2;
	logic             zero_s2;
	logic [2:0]       sgn_s2;
	logic [2:0][30:0] sm_s3;
	logic             zero_s3;
	logic [2:0]       sgn_s3;
	logic [2:0][61:0] sq_s4;
	logic [2:0][30:0] sm_s4;
	logic             zero_s4;
	logic [2:0]       sgn_s4;
	logic [63:0]      sum_s5;
	logic [2:0][30:0] sm_s5;
	logic             zero_s5;
	logic [2:0]       sgn_s5;

	// Square root stages.
	logic [63:0]      rt_rem_s  [1:SQRT_STEPS];
	logic [63:0]      rt_res_s  [1:SQRT_STEPS];
	logic [2:0][30:0] rt_sm_s   [1:SQRT_STEPS];
	logic [2:0]       rt_sgn_s  [1:SQRT_STEPS];
	logic             rt_zero_s [1:SQRT_STEPS];

	// Divider stages.
	logic [2:0][31:0] dv_rem_s  [1:DIV_STEPS];
	logic [2:0][30:0] dv_quo_s  [1:DIV_STEPS];
	logic [31:0]      dv_len_s  [1:DIV_STEPS];
	logic [2:0]       dv_sgn_s  [1:DIV_STEPS];
	logic             dv_zero_s [1:DIV_STEPS];

	logic [2:0][31:0] u_q;

	// Magnitudes and the largest of them.
	always_comb begin
		for (int i = 0; i < 3; i++) begin
			mag_c[i] = vec[i][32] ? 33'(33'd0 - vec[i]) : vec[i];
		end
		mx_c = mag_c[0];
		if (mag_c[1] > mx_c) begin
			mx_c = mag_c[1];
		end
		if (mag_c[2] > mx_c) begin
			mx_c = mag_c[2];
		end
	end

	// Position of the leading one of the largest magnitude.
	always_comb begin
		lead_c = '0;
		for (int b = 0; b < 33; b++) begin
			if (mx_s1[b]) begin
				lead_c = 6'(b);
			end
		end
	end

	// Shift so that the largest magnitude lies in [2^30, 2^31).
	always_comb begin
		for (int i = 0; i < 3; i++) begin
			if (lead_s2 >= 6'd30) begin
				sm_c[i] = 31'(mag_s2[i] >> (lead_s2 - 6'd30));
			end else begin
				sm_c[i] = 31'(64'(mag_s2[i]) << (6'd30 - lead_s2));
			end
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			mag_s1  <= mag_c;
			mx_s1   <= mx_c;
			sgn_s1  <= {vec[2][32], vec[1][32], vec[0][32]};
			mag_s2  <= mag_s1;
			lead_s2 <= lead_c;
			zero_s2 <= (mx_s1 == '0);
			sgn_s2  <= sgn_s1;
			sm_s3   <= sm_c;
			zero_s3 <= zero_s2;
			sgn_s3  <= sgn_s2;
			for (int i = 0; i < 3; i++) begin
				sq_s4[i] <= 62'(sm_s3[i]) * 62'(sm_s3[i]);
			end
			sm_s4   <= sm_s3;
			zero_s4 <= zero_s3;
			sgn_s4  <= sgn_s3;
			sum_s5  <= 64'(sq_s4[0]) + 64'(sq_s4[1]) + 64'(sq_s4[2]);
			sm_s5   <= sm_s4;
			zero_s5 <= zero_s4;
			sgn_s5  <= sgn_s4;
		end
	end

	// Integer square root, one result bit per stage.
	for (genvar k = 0; k < SQRT_STEPS; k++) begin : g_sqrt
		localparam logic [63:0] BIT = 64'd1 << (62 - 2 * k);
		logic [63:0]      rem_in;
		logic [63:0]      res_in;
		logic [63:0]      trial;
		logic [2:0][30:0] sm_in;
		logic [2:0]       sgn_in;
		logic             zero_in;
		if (k == 0) begin : g_src
			assign rem_in  = sum_s5;
			assign res_in  = '0;
			assign sm_in   = sm_s5;
			assign sgn_in  = sgn_s5;
			assign zero_in = zero_s5;
		end else begin : g_src
			assign rem_in  = rt_rem_s[k];
			assign res_in  = rt_res_s[k];
			assign sm_in   = rt_sm_s[k];
			assign sgn_in  = rt_sgn_s[k];
			assign zero_in = rt_zero_s[k];
		end
		assign trial = res_in + BIT;
		always_ff @(posedge clk) begin
			if (en) begin
				if (rem_in >= trial) begin
					rt_rem_s[k+1] <= rem_in - trial;
					rt_res_s[k+1] <= (res_in >> 1) + BIT;
				end else begin
					rt_rem_s[k+1] <= rem_in;
					rt_res_s[k+1] <= res_in >> 1;
				end
				rt_sm_s[k+1]   <= sm_in;
				rt_sgn_s[k+1]  <= sgn_in;
				rt_zero_s[k+1] <= zero_in;
			end
		end
	end

	// Restoring division of (m << 30) by the length, one quotient bit per stage.
	for (genvar k = 0; k < DIV_STEPS; k++) begin : g_div
		logic [2:0][32:0] x_in;
		logic [2:0][30:0] quo_in;
		logic [31:0]      len_in;
		logic [2:0]       sgn_in;
		logic             zero_in;
		if (k == 0) begin : g_src
			for (genvar i = 0; i < 3; i++) begin : g_lane
				assign x_in[i] = 33'(rt_sm_s[SQRT_STEPS][i]);
			end
			assign quo_in  = '0;
			assign len_in  = rt_res_s[SQRT_STEPS][31:0];
			assign sgn_in  = rt_sgn_s[SQRT_STEPS];
			assign zero_in = rt_zero_s[SQRT_STEPS];
		end else begin : g_src
			for (genvar i = 0; i < 3; i++) begin : g_lane
				assign x_in[i] = {dv_rem_s[k][i], 1'b0};
			end
			assign quo_in  = dv_quo_s[k];
			assign len_in  = dv_len_s[k];
			assign sgn_in  = dv_sgn_s[k];
			assign zero_in = dv_zero_s[k];
		end
		always_ff @(posedge clk) begin
			if (en) begin
				for (int i = 0; i < 3; i++) begin
					if (x_in[i] >= {1'b0, len_in}) begin
						dv_rem_s[k+1][i] <= 32'(x_in[i] - {1'b0, len_in});
						dv_quo_s[k+1][i] <= {quo_in[i][29:0], 1'b1};
					end else begin
						dv_rem_s[k+1][i] <= x_in[i][31:0];
						dv_quo_s[k+1][i] <= {quo_in[i][29:0], 1'b0};
					end
				end
				dv_len_s[k+1]  <= len_in;
				dv_sgn_s[k+1]  <= sgn_in;
				dv_zero_s[k+1] <= zero_in;
			end
		end
	end

	// Restore signs; a zero vector gives a zero result.
	always_ff @(posedge clk) begin
		if (en) begin
			for (int i = 0; i < 3; i++) begin
				if (dv_zero_s[DIV_STEPS]) begin
					u_q[i] <= '0;
				end else if (dv_sgn_s[DIV_STEPS][i]) begin
					u_q[i] <= 32'(32'd0 - {1'b0, dv_quo_s[DIV_STEPS][i]});
				end else begin
					u_q[i] <= {1'b0, dv_quo_s[DIV_STEPS][i]};
				end
			end
		end
	end

	assign unit_vec = u_q;

endmodule

`default_nettype wire

// ===== rtl/core/jittered_path_point_top.sv =====
// Throughput: one request per cycle while no result waits at the output; the two
// vector normalisers, each 69 stages deep (five front stages, 32 square root
// steps, 31 divider steps and a sign stage), set the depth.
// The pipeline stalls as a whole only while a result waits at the output.
// Reset clears every valid bit; payload registers are not reset.
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Jittered path point: top level
// Point on the segment between two 3D points, offset sideways by a seeded
// hash jitter that fades towards the end point.
// ----------------------------------------------------------------------------
module jittered_path_point_top import jpp_pkg::*; (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               in_valid,
	output logic               in_ready,
	input  logic signed [31:0] origin_x,
	input  logic signed [31:0] origin_y,
	input  logic signed [31:0] origin_z,
	input  logic signed [31:0] dest_x,
	input  logic signed [31:0] dest_y,
	input  logic signed [31:0] dest_z,
	input  logic signed [31:0] t_pos,
	input  logic [30:0]        spread,
	input  logic [31:0]        seed,
	output logic               out_valid,
	input  logic               out_ready,
	output logic signed [31:0] point_x,
	output logic signed [31:0] point_y,
	output logic signed [31:0] point_z
);

	localparam int unsigned LAT     = 7 + 2 * NORM_LAT;
	localparam int unsigned ST_Q    = 6;
	localparam int unsigned ST_L1F  = 4 + 2 * NORM_LAT;
	localparam int unsigned ST_ACC  = 6 + 2 * NORM_LAT;
	localparam int unsigned UD_DLY  = NORM_LAT + 1;
	localparam int unsigned SIDE_DLY = 2 * NORM_LAT - 4;

	logic           en;
	logic [LAT:1]   vld_q;

	// Front stages.
	logic [2:0][31:0] o_s1;
	logic [2:0][32:0] dir_s1;
	logic [16:0]      tc_s1;
	logic [31:0]      seed_s1;
	logic [30:0]      spread_s1;
	logic [2:0][50:0] pb_s2;
	logic [2:0][31:0] o_s2;
	logic             longp_s2;
	logic [9:0]       k_s2;
	logic [31:0]      sm1_s2;
	logic [31:0]      sm2_s2;
	logic [30:0]      amp_s2;
	front_t           front_s3;
	logic [31:0]      h1_s3;
	logic [31:0]      h2_s3;
	front_t           front_d;
	logic signed [16:0] q1;
	logic signed [16:0] q2;
	side_t            side_s7;
	side_t            side_d;

	// Back stages; numbering after the normalisers counts each as one.
	logic [2:0][31:0] ud;
	logic [2:0][31:0] ud_d;
	logic [2:0][32:0] cr_s8;
	logic [2:0][31:0] l1;
	logic [2:0][63:0] xa_s9;
	logic [2:0][63:0] xb_s9;
	logic [2:0][31:0] l1_s9;
	logic [2:0][31:0] l1f_s10;
	logic [2:0][32:0] l2f_s10;
	logic [32:0]      s1_s10;
	logic [32:0]      s2_s10;
	logic [2:0][33:0] base_s10;
	logic [2:0][65:0] m1_s11;
	logic [2:0][65:0] m2_s11;
	logic [2:0][33:0] base_s11;
	logic [2:0][37:0] acc_s12;
	logic [2:0][31:0] pt_q;

	// Combinational helpers.
	logic [2:0][32:0] dir_c;
	logic [16:0]      tc_c;
	logic [2:0][32:0] dmag_c;
	logic [15:0]      sq_c;
	logic             big_c;
	logic [26:0]      kprod_c;
	logic [47:0]      aprod_c;
	logic [48:0]      sp1_c;
	logic [48:0]      sp2_c;
	logic [31:0]      udy_mag_c;
	logic             steep_c;
	logic [2:0][64:0] xdiff_c;
	logic [2:0][66:0] tot_c;

	// The pipeline advances unless a finished result is held at the output.
	assign en       = !vld_q[LAT] || out_ready;
	assign in_ready = en;
	assign out_valid = vld_q[LAT];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q <= '0;
		end else if (en) begin
			vld_q <= {vld_q[LAT-1:1], in_valid};
		end
	end

	// Stage 1: travel direction and clamped position.
	always_comb begin
		dir_c[0] = {dest_x[31], dest_x} - {origin_x[31], origin_x};
		dir_c[1] = {dest_y[31], dest_y} - {origin_y[31], origin_y};
		dir_c[2] = {dest_z[31], dest_z} - {origin_z[31], origin_z};
		if (t_pos[31]) begin
			tc_c = '0;
		end else if (t_pos > 32'sd65536) begin
			tc_c = ONE_Q16;
		end else begin
			tc_c = t_pos[16:0];
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			o_s1      <= {origin_z, origin_y, origin_x};
			dir_s1    <= dir_c;
			tc_s1     <= tc_c;
			seed_s1   <= seed;
			spread_s1 <= spread;
		end
	end

	// Stage 2: base products, short path test, hash seeds and amplitude.
	always_comb begin
		big_c = 1'b0;
		sq_c  = '0;
		for (int i = 0; i < 3; i++) begin
			dmag_c[i] = dir_s1[i][32] ? 33'(33'd0 - dir_s1[i]) : dir_s1[i];
			if (dmag_c[i] >= SHORT_MAG) begin
				big_c = 1'b1;
			end
			sq_c = sq_c + 16'(dmag_c[i][6:0]) * 16'(dmag_c[i][6:0]);
		end
		kprod_c = 27'(tc_s1) * K_SCALE;
		aprod_c = 48'(spread_s1) * 48'(ONE_Q16 - tc_s1);
	end

	always_ff @(posedge clk) begin
		if (en) begin
			for (int i = 0; i < 3; i++) begin
				pb_s2[i] <= $signed(dir_s1[i]) * $signed({1'b0, tc_s1});
			end
			o_s2     <= o_s1;
			longp_s2 <= big_c || (sq_c >= SHORT_SQ);
			k_s2     <= kprod_c[25:16];
			sm1_s2   <= 32'(seed_s1 * SEED_MUL1);
			sm2_s2   <= 32'(seed_s1 * SEED_MUL2);
			amp_s2   <= aprod_c[46:16];
		end
	end

	// Stage 3: base point and hash keys.
	always_ff @(posedge clk) begin
		if (en) begin
			for (int i = 0; i < 3; i++) begin
				front_s3.base[i] <= {{2{o_s2[i][31]}}, o_s2[i]} + pb_s2[i][49:16];
			end
			front_s3.longp <= longp_s2;
			front_s3.amp   <= amp_s2;
			h1_s3          <= sm1_s2 + 32'(k_s2);
			h2_s3          <= sm2_s2 + 32'(k_s2) + HASH_ADD;
		end
	end

	// Stages 4 to 6: hashes, with the other front data alongside.
	jpp_hash u_hash1 (
		.clk  (clk),
		.en   (en),
		.key  (h1_s3),
		.offs (q1)
	);

	jpp_hash u_hash2 (
		.clk  (clk),
		.en   (en),
		.key  (h2_s3),
		.offs (q2)
	);

	jpp_delay #(
		.WIDTH ($bits(front_t)),
		.DEPTH (3)
	) u_front_dly (
		.clk  (clk),
		.en   (en),
		.din  (front_s3),
		.dout (front_d)
	);

	// Stage 7: scaled jitter offsets.
	assign sp1_c = q1 * $signed({1'b0, front_d.amp});
	assign sp2_c = q2 * $signed({1'b0, front_d.amp});

	always_ff @(posedge clk) begin
		if (en) begin
			side_s7.base  <= front_d.base;
			side_s7.longp <= front_d.longp;
			side_s7.s1    <= sp1_c[48:16];
			side_s7.s2    <= sp2_c[48:16];
		end
	end

	jpp_delay #(
		.WIDTH ($bits(side_t)),
		.DEPTH (SIDE_DLY)
	) u_side_dly (
		.clk  (clk),
		.en   (en),
		.din  (side_s7),
		.dout (side_d)
	);

	// Unit travel direction.
	jpp_norm u_norm_dir (
		.clk      (clk),
		.en       (en),
		.vec      (dir_s1),
		.unit_vec (ud)
	);

	// Cross product with the helper axis.
	always_comb begin
		udy_mag_c = ud[1][31] ? 32'(32'd0 - ud[1]) : ud[1];
		steep_c   = udy_mag_c > STEEP_Y;
	end

	always_ff @(posedge clk) begin
		if (en) begin
			if (steep_c) begin
				cr_s8[0] <= '0;
				cr_s8[1] <= {ud[2][31], ud[2]};
				cr_s8[2] <= 33'(33'd0 - {ud[1][31], ud[1]});
			end else begin
				cr_s8[0] <= 33'(33'd0 - {ud[2][31], ud[2]});
				cr_s8[1] <= '0;
				cr_s8[2] <= {ud[0][31], ud[0]};
			end
		end
	end

	// First lateral vector.
	jpp_norm u_norm_lat (
		.clk      (clk),
		.en       (en),
		.vec      (cr_s8),
		.unit_vec (l1)
	);

	jpp_delay #(
		.WIDTH (96),
		.DEPTH (UD_DLY)
	) u_ud_dly (
		.clk  (clk),
		.en   (en),
		.din  (ud),
		.dout (ud_d)
	);

	// Second lateral vector: products of direction and first lateral vector.
	always_ff @(posedge clk) begin
		if (en) begin
			xa_s9[0] <= $signed(ud_d[1]) * $signed(l1[2]);
			xb_s9[0] <= $signed(ud_d[2]) * $signed(l1[1]);
			xa_s9[1] <= $signed(ud_d[2]) * $signed(l1[0]);
			xb_s9[1] <= $signed(ud_d[0]) * $signed(l1[2]);
			xa_s9[2] <= $signed(ud_d[0]) * $signed(l1[1]);
			xb_s9[2] <= $signed(ud_d[1]) * $signed(l1[0]);
			l1_s9    <= l1;
		end
	end

	always_comb begin
		for (int i = 0; i < 3; i++) begin
			xdiff_c[i] = {xa_s9[i][63], xa_s9[i]} - {xb_s9[i][63], xb_s9[i]};
		end
	end

	// Pick the lateral vectors; a short path uses the fixed x and z axes.
	always_ff @(posedge clk) begin
		if (en) begin
			if (side_d.longp) begin
				l1f_s10 <= l1_s9;
				for (int i = 0; i < 3; i++) begin
					l2f_s10[i] <= xdiff_c[i][62:30];
				end
			end else begin
				l1f_s10[0] <= ONE_Q30;
				l1f_s10[1] <= '0;
				l1f_s10[2] <= '0;
				l2f_s10[0] <= '0;
				l2f_s10[1] <= '0;
				l2f_s10[2] <= 33'(ONE_Q30);
			end
			s1_s10   <= side_d.s1;
			s2_s10   <= side_d.s2;
			base_s10 <= side_d.base;
		end
	end

	// Lateral offsets.
	always_ff @(posedge clk) begin
		if (en) begin
			for (int i = 0; i < 3; i++) begin
				m1_s11[i] <= $signed(l1f_s10[i]) * $signed(s1_s10);
				m2_s11[i] <= $signed(l2f_s10[i]) * $signed(s2_s10);
			end
			base_s11 <= base_s10;
		end
	end

	// Sum, scale back from Q2.30 and add the base point.
	always_comb begin
		for (int i = 0; i < 3; i++) begin
			tot_c[i] = {m1_s11[i][65], m1_s11[i]} + {m2_s11[i][65], m2_s11[i]};
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			for (int i = 0; i < 3; i++) begin
				acc_s12[i] <= {tot_c[i][66], tot_c[i][66:30]}
					+ {{4{base_s11[i][33]}}, base_s11[i]};
			end
		end
	end

	// Saturate to the 32-bit signed range; this is the output register.
	always_ff @(posedge clk) begin
		if (en) begin
			for (int i = 0; i < 3; i++) begin
				if (acc_s12[i][37:31] == '0 || acc_s12[i][37:31] == '1) begin
					pt_q[i] <= acc_s12[i][31:0];
				end else if (acc_s12[i][37]) begin
					pt_q[i] <= 32'h8000_0000;
				end else begin
					pt_q[i] <= 32'h7fff_ffff;
				end
			end
		end
	end

	assign point_x = pt_q[0];
	assign point_y = pt_q[1];
	assign point_z = pt_q[2];

	// The first lateral vector never leaves the unit range.
	a_lat_range: assert property (@(posedge clk) disable iff (!arst_n)
		vld_q[ST_L1F] |->
			($signed(l1f_s10[0]) <= ONE_Q30 && $signed(l1f_s10[0]) >= -ONE_Q30 &&
			 $signed(l1f_s10[1]) <= ONE_Q30 && $signed(l1f_s10[1]) >= -ONE_Q30 &&
			 $signed(l1f_s10[2]) <= ONE_Q30 && $signed(l1f_s10[2]) >= -ONE_Q30))
		else $error("lateral vector out of range");

	// Hash offsets stay within plus or minus one half.
	a_offs_range: assert property (@(posedge clk) disable iff (!arst_n)
		vld_q[ST_Q] |->
			(q1 >= -17'sd32768 && q1 <= 17'sd32768 &&
			 q2 >= -17'sd32768 && q2 <= 17'sd32768))
		else $error("hash offset out of range");

	// A positive overflow of x reaches the output as the largest value.
	a_sat_high: assert property (@(posedge clk) disable iff (!arst_n)
		vld_q[ST_ACC] && en && ($signed(acc_s12[0]) > 38'sh7fffffff) |=>
			(point_x == 32'sh7fffffff))
		else $error("x did not saturate");

endmodule

`default_nettype wire
